// ----- src/mpfd_pkg.sv -----
package mpfd_pkg;

    // Command codes carried on s_tuser
    typedef enum logic [2:0] {
        OP_POINT = 3'd0,
        OP_READ  = 3'd1,
        OP_HLINE = 3'd2,
        OP_VLINE = 3'd3,
        OP_FILL  = 3'd4
    } opcode_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // latch a new command word
        logic clear_wr;  // write zero at sweep address
        logic fill_wr;   // write fill pattern at sweep address
        logic rd;        // read byte at cursor address
        logic rmw_wr;    // modify and write back byte at cursor address
        logic step;      // advance cursor
        logic out_load;  // move working result into output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    cursor_last;
        logic    sweep_last;
    } dp_status_t;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

endpackage

// ----- src/mpfd_ram.sv -----
module mpfd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mpfd_ctrl.sv -----
module mpfd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mpfd_pkg::ctrl_cmd_t    cmd,
    input  mpfd_pkg::dp_status_t   status
);

    mpfd_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpfd_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpfd_pkg::ST_CLEAR: begin
                if (status.sweep_last) state_next = mpfd_pkg::ST_IDLE;
            end
            mpfd_pkg::ST_IDLE: begin
                if (in_valid) state_next = mpfd_pkg::ST_DISPATCH;
            end
            mpfd_pkg::ST_DISPATCH: begin
                case (status.op)
                    mpfd_pkg::OP_POINT,
                    mpfd_pkg::OP_READ,
                    mpfd_pkg::OP_HLINE,
                    mpfd_pkg::OP_VLINE: state_next = mpfd_pkg::ST_READ;
                    mpfd_pkg::OP_FILL:  state_next = mpfd_pkg::ST_FILL;
                    default:            state_next = mpfd_pkg::ST_DONE;
                endcase
            end
            mpfd_pkg::ST_READ: begin
                state_next = mpfd_pkg::ST_MODIFY;
            end
            mpfd_pkg::ST_MODIFY: begin
                state_next = status.cursor_last ? mpfd_pkg::ST_DONE : mpfd_pkg::ST_READ;
            end
            mpfd_pkg::ST_FILL: begin
                if (status.sweep_last) state_next = mpfd_pkg::ST_DONE;
            end
            mpfd_pkg::ST_DONE: begin
                if (!out_valid_reg || out_ready) state_next = mpfd_pkg::ST_IDLE;
            end
            default: begin
                state_next = mpfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            mpfd_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            mpfd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            mpfd_pkg::ST_READ: begin
                cmd.rd = 1'b1;
            end
            mpfd_pkg::ST_MODIFY: begin
                cmd.rmw_wr = 1'b1;
                cmd.step   = !status.cursor_last;
            end
            mpfd_pkg::ST_FILL: begin
                cmd.fill_wr = 1'b1;
            end
            mpfd_pkg::ST_DONE: begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Result word valid: set on load, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/mpfd_datapath.sv -----
module mpfd_datapath #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           in_opcode,
    input  logic [7:0]           in_x_coord,
    input  logic [7:0]           in_y_coord,
    input  logic [7:0]           in_end_coord,
    input  logic                 in_color,
    input  logic [7:0]           in_fill_pattern,
    output logic                 out_ok,
    output logic                 out_pixel,
    input  mpfd_pkg::ctrl_cmd_t  cmd,
    output mpfd_pkg::dp_status_t status
);

    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [8:0]    WIDTH_W   = 9'(WIDTH);
    localparam logic [8:0]    HEIGHT_W  = 9'(HEIGHT);
    localparam logic [5:0]    PAGES_W   = 6'(PAGES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Bits of a page that hold rows below HEIGHT
    function automatic logic [7:0] page_mask(input logic [4:0] pg);
        int first;
        int rows;
        first = int'(pg) * 8;
        if (first >= HEIGHT) begin
            return 8'h00;
        end
        rows = HEIGHT - first;
        if (rows >= 8) begin
            return mpfd_pkg::BYTE_ONES;
        end
        return 8'((1 << rows) - 1);
    endfunction

    // Command word
    mpfd_pkg::opcode_t op_reg;
    logic [7:0]        x_reg, y_reg, lo_reg, hi_reg;
    logic [7:0]        cursor_reg, last_reg;
    logic              color_reg;
    logic [7:0]        pat_reg;
    logic [AW-1:0]     sweep_reg;
    logic              res_ok_reg, res_pixel_reg;
    logic              out_ok_reg, out_pixel_reg;

    logic [7:0]        lo_next, hi_next, cursor_next, last_next;
    logic              res_ok_next;

    // Line ends in order; points walk a single column
    always_comb begin
        lo_next     = in_x_coord;
        hi_next     = in_x_coord;
        res_ok_next = 1'b0;
        case (mpfd_pkg::opcode_t'(in_opcode))
            mpfd_pkg::OP_POINT, mpfd_pkg::OP_READ: begin
                res_ok_next = ({1'b0, in_x_coord} < WIDTH_W) &&
                              ({1'b0, in_y_coord} < HEIGHT_W);
            end
            mpfd_pkg::OP_HLINE: begin
                lo_next     = (in_x_coord > in_end_coord) ? in_end_coord : in_x_coord;
                hi_next     = (in_x_coord > in_end_coord) ? in_x_coord : in_end_coord;
                res_ok_next = 1'b1;
            end
            mpfd_pkg::OP_VLINE: begin
                lo_next     = (in_y_coord > in_end_coord) ? in_end_coord : in_y_coord;
                hi_next     = (in_y_coord > in_end_coord) ? in_y_coord : in_end_coord;
                res_ok_next = 1'b1;
            end
            mpfd_pkg::OP_FILL: begin
                res_ok_next = 1'b1;
            end
            default: begin
                res_ok_next = 1'b0;
            end
        endcase
        // vertical lines walk pages, the rest walk columns
        if (mpfd_pkg::opcode_t'(in_opcode) == mpfd_pkg::OP_VLINE) begin
            cursor_next = {3'b000, lo_next[7:3]};
            last_next   = {3'b000, hi_next[7:3]};
        end else begin
            cursor_next = lo_next;
            last_next   = hi_next;
        end
    end

    // Cursor address and write mask
    logic [4:0]    cur_page;
    logic [7:0]    cur_col;
    logic          in_range;
    logic [15:0]   addr_full;
    logic [AW-1:0] rmw_addr;
    logic [7:0]    line_mask, wr_mask;
    logic [7:0]    rdata, rmw_data;

    always_comb begin
        if (op_reg == mpfd_pkg::OP_VLINE) begin
            cur_page  = cursor_reg[4:0];
            cur_col   = x_reg;
            line_mask = mpfd_pkg::BYTE_ONES;
            if (cursor_reg[4:0] == lo_reg[7:3]) begin
                line_mask = line_mask & 8'(mpfd_pkg::BYTE_ONES << lo_reg[2:0]);
            end
            if (cursor_reg[4:0] == hi_reg[7:3]) begin
                line_mask = line_mask & 8'(mpfd_pkg::BYTE_ONES >> (3'd7 - hi_reg[2:0]));
            end
        end else begin
            cur_page  = y_reg[7:3];
            cur_col   = cursor_reg;
            line_mask = 8'(8'h01 << y_reg[2:0]);
        end
        in_range  = ({1'b0, cur_col} < WIDTH_W) && ({1'b0, cur_page} < PAGES_W);
        addr_full = 16'(cur_page) * 16'(WIDTH) + 16'(cur_col);
        rmw_addr  = addr_full[AW-1:0];
        wr_mask   = line_mask & page_mask(cur_page);
        rmw_data  = color_reg ? (rdata | wr_mask) : (rdata & ~wr_mask);
    end

    // Store write port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rmw_addr;
        ram_wdata = rmw_data;
        if (cmd.clear_wr || cmd.fill_wr) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = cmd.fill_wr ? pat_reg : 8'h00;
        end else if (cmd.rmw_wr && in_range && op_reg != mpfd_pkg::OP_READ) begin
            ram_we = 1'b1;
        end
    end

    mpfd_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rmw_addr),
        .rdata (rdata)
    );

    // Sweep counter for clearing pass and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.load) begin
            sweep_reg <= '0;
        end else if (cmd.clear_wr || cmd.fill_wr) begin
            sweep_reg <= sweep_reg + AW'(1);
        end
    end

    // Command word and cursor
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= mpfd_pkg::opcode_t'(in_opcode);
            x_reg      <= in_x_coord;
            y_reg      <= in_y_coord;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            cursor_reg <= cursor_next;
            last_reg   <= last_next;
            color_reg  <= in_color;
            pat_reg    <= in_fill_pattern;
        end else if (cmd.step) begin
            cursor_reg <= cursor_reg + 8'd1;
        end
    end

    // Working result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_ok_reg    <= res_ok_next;
            res_pixel_reg <= 1'b0;
        end else if (cmd.rmw_wr && op_reg == mpfd_pkg::OP_READ) begin
            res_pixel_reg <= res_ok_reg & rdata[y_reg[2:0]];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ok_reg    <= res_ok_reg;
            out_pixel_reg <= res_pixel_reg;
        end
    end

    assign out_ok             = out_ok_reg;
    assign out_pixel          = out_pixel_reg;
    assign status.op          = op_reg;
    assign status.cursor_last = (cursor_reg == last_reg);
    assign status.sweep_last  = (sweep_reg == LAST_ADDR);

    // cmd.rd only marks the read cycle; the read port follows the cursor always
    logic unused_rd;
    assign unused_rd = cmd.rd;

endmodule

// ----- src/mono_page_framebuffer_draw_core.sv -----
// Monochrome page frame store with drawing commands. Pixel (x, y) is bit y%8
// of byte (y/8)*WIDTH + x in a single-port-write, registered-read store of
// ceil(HEIGHT/8)*WIDTH bytes. Each command word yields one result word.
// After reset the store is swept to zero, one byte per cycle, over all
// ceil(HEIGHT/8)*WIDTH bytes (1024 by default) before s_tready first rises.
// Point, read and line commands work the store by read-modify-write: point
// and read point do one, a horizontal line one per column from its lower
// to its upper end, a vertical line one per page touched, and fill writes
// each byte once. A new command is taken while the last result still waits
// on m_tready; its result waits until that word is taken.
module mono_page_framebuffer_draw_core #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // x_coord[7:0], y_coord[15:8], end_coord[23:16],
                                   // color[24], fill_pattern[32:25], zero[39:33]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel[0], zero[7:1]
    output logic [0:0]  m_tuser    // ok[0]
);

    mpfd_pkg::ctrl_cmd_t  cmd;
    mpfd_pkg::dp_status_t status;
    logic                 out_ok, out_pixel;

    mpfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    mpfd_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_opcode       (s_tuser),
        .in_x_coord      (s_tdata[7:0]),
        .in_y_coord      (s_tdata[15:8]),
        .in_end_coord    (s_tdata[23:16]),
        .in_color        (s_tdata[24]),
        .in_fill_pattern (s_tdata[32:25]),
        .out_ok          (out_ok),
        .out_pixel       (out_pixel),
        .cmd             (cmd),
        .status          (status)
    );

    assign m_tdata = {7'b0000000, out_pixel};
    assign m_tuser = out_ok;

    // Padding bits of the command word carry nothing
    logic [6:0] unused_pad;
    assign unused_pad = s_tdata[39:33];

endmodule
